// ===== design/orthographic_view_projection_core_assert.svh =====
// assertion macros shared by the projection core modules
`ifndef ORTHOGRAPHIC_VIEW_PROJECTION_CORE_ASSERT_SVH
`define ORTHOGRAPHIC_VIEW_PROJECTION_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define OVP_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ovp assertion failed");

// next-cycle implication
`define OVP_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ovp assertion failed");

`endif

// ===== design/ovp_pkg.sv =====
// shared constants, types and helpers of the orthographic projection core
`timescale 1ns / 1ps

package ovp_pkg;

	localparam int COORD_W = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int COEF_F  = 16;
	localparam int COEF_W  = COEF_F + 2;

	// coefficient derivation widths
	localparam int SQ_W    = 2 * CFG_W;
	localparam int DVD_W   = SQ_W + 2 * COEF_F;
	localparam int REM_W   = SQ_W + 1;
	localparam int CNT_W   = $clog2(DVD_W);
	localparam int RV_W    = 2 * COEF_F + 1;
	localparam int RES_W   = RV_W + 1;
	localparam int Q_F     = 28;
	localparam int Q_W     = Q_F + 1;
	localparam int Q_SH    = Q_F - COEF_F;
	localparam int ANG_W   = 16;
	localparam int AMAG_W  = ANG_W - 2;
	localparam int PI_W    = 31;
	localparam logic [PI_W-1:0] TWO_PI_Q28 = 31'd1686629713;
	localparam logic [Q_W-1:0]  Q_ONE = {1'b1, {Q_F{1'b0}}};

	// datapath widths
	localparam int X1_W    = COEF_W + COORD_W + 1;
	localparam int E_W     = X1_W + 3;
	localparam int PROD_W  = COEF_W + E_W;
	localparam int TRQ_W   = PROD_W - COEF_F;
	localparam int ZOOM_W  = 16;
	localparam int PR_W    = E_W - 1 + ZOOM_W;
	localparam int PLACE_SH = COEF_F + 8;
	localparam int IP_W    = PR_W - PLACE_SH;
	localparam int SUM_W   = IP_W + 2;

	// register reset values
	localparam logic signed [CFG_W-1:0] RST_VIEW_X = -16'sd1;
	localparam logic signed [CFG_W-1:0] RST_VIEW_Y = 16'sd1;
	localparam logic signed [CFG_W-1:0] RST_VIEW_Z = -16'sd1;
	localparam logic [ZOOM_W-1:0]       RST_ZOOM   = 16'd307;

	typedef enum logic [IDX_W-1:0] {
		REG_VIEW_X   = 3'd0,
		REG_VIEW_Y   = 3'd1,
		REG_VIEW_Z   = 3'd2,
		REG_ZOOM     = 3'd3,
		REG_ANGLE    = 3'd4,
		REG_OFFSET_X = 3'd5,
		REG_OFFSET_Y = 3'd6
	} cfg_reg_t;

	typedef enum logic [4:0] {
		C_SQX, C_SQY, C_SQZ, C_SUM, C_TSUM,
		C_RLOAD, C_DIV, C_RINIT, C_ROOT, C_STORE,
		C_ANG_T, C_ANG_T2, C_H_MUL, C_H_SUB, C_SFIN, C_FINAL, C_DONE
	} coef_state_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] ca;
		logic signed [COEF_W-1:0] sa;
		logic signed [COEF_W-1:0] cb;
		logic signed [COEF_W-1:0] sb;
		logic signed [COEF_W-1:0] cc;
		logic signed [COEF_W-1:0] sc;
		logic                     degenerate;
		logic                     ready;
	} coef_t;

	// reciprocals of the series divisors 42, 20, 6 (sine) and 56, 30, 12, 2 (cosine),
	// exact floor division for numerators below 2^28
	function automatic logic [Q_W-1:0] horner_recip(input logic [2:0] h);
		logic [Q_W-1:0] m;
		case (h)
			3'd0: m = Q_W'(409044505);
			3'd1: m = Q_W'(429496730);
			3'd2: m = Q_W'(357913942);
			3'd3: m = Q_W'(306783379);
			3'd4: m = Q_W'(286331154);
			3'd5: m = Q_W'(357913942);
			3'd6: m = Q_W'(268435456);
			default: m = '0;
		endcase
		return m;
	endfunction

	// right shift that goes with each reciprocal
	function automatic logic [5:0] horner_shift(input logic [2:0] h);
		logic [5:0] s;
		case (h)
			3'd0: s = 6'd34;
			3'd1: s = 6'd33;
			3'd2: s = 6'd31;
			3'd3: s = 6'd34;
			3'd4: s = 6'd33;
			3'd5: s = 6'd32;
			3'd6: s = 6'd29;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	// product in Q(COEF_F) scaled down, truncated toward zero
	function automatic logic signed [TRQ_W-1:0] trunc_q(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] b;
		b = p + (p[PROD_W-1] ? {{(PROD_W-COEF_F){1'b0}}, {COEF_F{1'b1}}} : {PROD_W{1'b0}});
		return b[PROD_W-1:COEF_F];
	endfunction

endpackage

// ===== design/ovp_coef.sv =====
// sequencer deriving the six rotation coefficients from the view registers
`timescale 1ns / 1ps
`include "orthographic_view_projection_core_assert.svh"

module ovp_coef import ovp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    restart,
	input  logic signed [CFG_W-1:0] view_x,
	input  logic signed [CFG_W-1:0] view_y,
	input  logic signed [CFG_W-1:0] view_z,
	input  logic [ANG_W-1:0]        view_angle,
	output coef_t                   coefs
);

	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DVD_W - 1);
	localparam logic [2:0]       SIN_LAST  = 3'd2;
	localparam logic [2:0]       COS_FIRST = 3'd3;
	localparam logic [2:0]       COS_LAST  = 3'd6;
	localparam logic [RES_W-1:0] ROOT_MAX  = {{(RES_W-COEF_F-1){1'b0}}, 1'b1, {COEF_F{1'b0}}};

	coef_state_t state_q, state_d;
	logic        degen_q;
	logic [1:0]  job_q;

	logic [SQ_W-1:0]  sqx_q, sqy_q, sqz_q, s_sum_q, t_sum_q;
	logic [DVD_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [SQ_W-1:0]  den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RV_W-1:0]  rv_q, bit_q;
	logic [RES_W-1:0] res_q;
	logic [Q_W-1:0]   t_q, t2_q, acc_q, sin_q;
	logic [2:0]       hidx_q;
	logic signed [COEF_W-1:0] ca_q, sa_q, cb_q, sb_q, cc_q, sc_q;

	// squares of the view components
	logic signed [CFG_W-1:0] sq_in;
	logic signed [SQ_W-1:0]  sq_p;

	// shared Q28 multiplier
	logic [Q_W-1:0]     mul_a, mul_b;
	logic [2*Q_W-1:0]   mul_p;
	logic [Q_W-1:0]     mul_q;
	logic [Q_W-1:0]     h_quo;

	// divider and root steps
	logic [REM_W-1:0] rem_sh, rem_n;
	logic [REM_W:0]   rem_diff;
	logic             div_ge;
	logic [RES_W-1:0] trial, res_n;
	logic             root_ge;
	logic [SQ_W-1:0]  num_sel, den_sel;

	// angle split
	logic [ANG_W-1:0]        ang_sum;
	logic [1:0]              quad;
	logic                    rneg;
	logic [AMAG_W-1:0]       rmag;
	logic [AMAG_W+PI_W-1:0]  ang_p;
	logic [Q_W:0]            sn_rnd, cs_rnd;
	logic signed [COEF_W-1:0] sn_mag, cs_mag, sn_s;
	logic signed [COEF_W-1:0] root_mag;

	always_comb begin
		case (state_q)
			C_SQX:   sq_in = view_x;
			C_SQY:   sq_in = view_y;
			default: sq_in = view_z;
		endcase
		sq_p = sq_in * sq_in;
	end

	always_comb begin
		case (state_q)
			C_ANG_T2: begin
				mul_a = t_q;
				mul_b = t_q;
			end
			C_SFIN: begin
				mul_a = t_q;
				mul_b = acc_q;
			end
			// series division as a reciprocal multiply
			C_H_SUB: begin
				mul_a = dvd_q[Q_W-1:0];
				mul_b = horner_recip(hidx_q);
			end
			default: begin
				mul_a = t2_q;
				mul_b = acc_q;
			end
		endcase
		mul_p = mul_a * mul_b;
		mul_q = mul_p[Q_F+Q_W-1:Q_F];
		h_quo = Q_W'(mul_p >> horner_shift(hidx_q));
	end

	always_comb begin
		rem_sh   = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
		rem_diff = {1'b0, rem_sh} - {2'b00, den_q};
		div_ge   = !rem_diff[REM_W];
		rem_n    = div_ge ? rem_diff[REM_W-1:0] : rem_sh;
	end

	always_comb begin
		trial   = res_q + RES_W'(bit_q);
		root_ge = RES_W'(rv_q) >= trial;
		res_n   = root_ge ? (res_q >> 1) + RES_W'(bit_q) : res_q >> 1;
	end

	always_comb begin
		case (job_q)
			2'd0:    num_sel = sqy_q;
			2'd1:    num_sel = sqx_q;
			2'd2:    num_sel = sqz_q;
			default: num_sel = s_sum_q;
		endcase
		den_sel  = job_q[1] ? t_sum_q : s_sum_q;
		root_mag = COEF_W'(res_q);
	end

	// residual of at most an eighth of a turn around the nearest quadrant
	always_comb begin
		ang_sum = view_angle + {3'b001, {(ANG_W-3){1'b0}}};
		quad    = ang_sum[ANG_W-1:ANG_W-2];
		rneg    = !ang_sum[AMAG_W-1];
		rmag    = rneg ? {1'b1, {(AMAG_W-1){1'b0}}} - ang_sum[AMAG_W-1:0]
		               : ang_sum[AMAG_W-1:0] - {1'b1, {(AMAG_W-1){1'b0}}};
		ang_p   = rmag * TWO_PI_Q28;
		sn_rnd  = {1'b0, sin_q} + (Q_W+1)'(1 << (Q_SH - 1));
		cs_rnd  = {1'b0, acc_q} + (Q_W+1)'(1 << (Q_SH - 1));
		sn_mag  = COEF_W'(sn_rnd >> Q_SH);
		cs_mag  = COEF_W'(cs_rnd >> Q_SH);
		sn_s    = rneg ? -sn_mag : sn_mag;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_SQX:   state_d = C_SQY;
			C_SQY:   state_d = C_SQZ;
			C_SQZ:   state_d = C_SUM;
			C_SUM:   state_d = C_TSUM;
			C_TSUM:  state_d = (s_sum_q == '0) ? C_ANG_T : C_RLOAD;
			C_RLOAD: state_d = C_DIV;
			C_DIV: begin
				if (cnt_q == CNT_LAST)
					state_d = C_RINIT;
			end
			C_RINIT: state_d = C_ROOT;
			C_ROOT: begin
				if (bit_q[0])
					state_d = C_STORE;
			end
			C_STORE:  state_d = (job_q == 2'd3) ? C_ANG_T : C_RLOAD;
			C_ANG_T:  state_d = C_ANG_T2;
			C_ANG_T2: state_d = C_H_MUL;
			C_H_MUL:  state_d = C_H_SUB;
			C_H_SUB: begin
				if (hidx_q == SIN_LAST)
					state_d = C_SFIN;
				else if (hidx_q == COS_LAST)
					state_d = C_FINAL;
				else
					state_d = C_H_MUL;
			end
			C_SFIN:  state_d = C_H_MUL;
			C_FINAL: state_d = C_DONE;
			C_DONE:  state_d = C_DONE;
			default: state_d = C_SQX;
		endcase
		if (restart)
			state_d = C_SQX;
	end

	always_comb begin
		coefs.ca         = ca_q;
		coefs.sa         = sa_q;
		coefs.cb         = cb_q;
		coefs.sb         = sb_q;
		coefs.cc         = cc_q;
		coefs.sc         = sc_q;
		coefs.degenerate = degen_q;
		coefs.ready      = (state_q == C_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_SQX;
			degen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == C_TSUM)
				degen_q <= (s_sum_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_SQX: sqx_q <= sq_p;
			C_SQY: sqy_q <= sq_p;
			C_SQZ: sqz_q <= sq_p;
			C_SUM: s_sum_q <= sqx_q + sqy_q;
			C_TSUM: begin
				t_sum_q <= s_sum_q + sqz_q;
				job_q   <= '0;
				if (s_sum_q == '0) begin
					ca_q <= '0;
					sa_q <= '0;
					cb_q <= '0;
					sb_q <= '0;
				end
			end
			C_RLOAD: begin
				dvd_q <= {num_sel, {(2*COEF_F){1'b0}}};
				den_q <= den_sel;
				rem_q <= '0;
				cnt_q <= '0;
			end
			C_DIV: begin
				dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
				rem_q <= rem_n;
				cnt_q <= cnt_q + 1'b1;
			end
			C_RINIT: begin
				rv_q  <= dvd_q[RV_W-1:0];
				res_q <= '0;
				bit_q <= {1'b1, {(RV_W-1){1'b0}}};
			end
			C_ROOT: begin
				if (root_ge)
					rv_q <= rv_q - trial[RV_W-1:0];
				res_q <= res_n;
				bit_q <= bit_q >> 2;
			end
			C_STORE: begin
				case (job_q)
					2'd0:    ca_q <= view_y[CFG_W-1] ? -root_mag : root_mag;
					2'd1:    sa_q <= (!view_x[CFG_W-1] && view_x != '0) ? -root_mag : root_mag;
					2'd2:    sb_q <= view_z[CFG_W-1] ? -root_mag : root_mag;
					default: cb_q <= root_mag;
				endcase
				job_q <= job_q + 1'b1;
			end
			C_ANG_T: begin
				t_q    <= ang_p[Q_W+ANG_W-1:ANG_W];
				hidx_q <= '0;
			end
			C_ANG_T2: t2_q <= mul_q;
			C_H_MUL: begin
				// first step of each series divides t^2 directly
				if (hidx_q == '0 || hidx_q == COS_FIRST)
					dvd_q <= DVD_W'(t2_q);
				else
					dvd_q <= DVD_W'(mul_q);
			end
			C_H_SUB: begin
				acc_q <= Q_ONE - h_quo;
				if (hidx_q != SIN_LAST && hidx_q != COS_LAST)
					hidx_q <= hidx_q + 1'b1;
			end
			C_SFIN: begin
				sin_q  <= mul_q;
				hidx_q <= hidx_q + 1'b1;
			end
			C_FINAL: begin
				unique case (quad)
					2'd0: begin
						cc_q <= cs_mag;
						sc_q <= sn_s;
					end
					2'd1: begin
						cc_q <= -sn_s;
						sc_q <= cs_mag;
					end
					2'd2: begin
						cc_q <= -cs_mag;
						sc_q <= -sn_s;
					end
					default: begin
						cc_q <= sn_s;
						sc_q <= -cs_mag;
					end
				endcase
			end
			default: ;
		endcase
	end

	`OVP_ASSERT_NEXT(a_restart_busy, restart, !coefs.ready)
	`OVP_ASSERT_IMPL(a_degen_zero, coefs.ready && coefs.degenerate, coefs.ca == '0 && coefs.sa == '0)
	`OVP_ASSERT_IMPL(a_root_range, state_q == C_STORE, res_q <= ROOT_MAX)

endmodule

// ===== design/ovp_xform.sv =====
// rotation stages: azimuth, tilt and in-plane rotation of one point
`timescale 1ns / 1ps

module ovp_xform import ovp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_v,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  coef_t                     coefs,
	output logic                      ev,
	output logic signed [E_W-1:0]     ex,
	output logic signed [E_W-1:0]     ey
);

	localparam int P1_W  = COEF_W + COORD_W;
	localparam int SBY_W = COEF_W + X1_W;
	localparam int SZ_W  = COEF_W + E_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [P1_W-1:0]    cax_s1, say_s1, cay_s1, sax_s1;
	logic signed [COORD_W-1:0] z_s1, z_s2;
	logic signed [X1_W-1:0]    x1_s2, y1_s2, x1_s3, x1_s4;
	logic signed [P1_W-1:0]    cbz_s3;
	logic signed [SBY_W-1:0]   sby_s3;
	logic signed [E_W-1:0]     z2_s4;
	logic signed [SBY_W-1:0]   pcx_s5, psx_s5;
	logic signed [SZ_W-1:0]    psz_s5, pcz_s5;
	logic signed [E_W-1:0]     tcx_s6, tsz_s6, tcz_s6, tsx_s6;
	logic signed [E_W-1:0]     ex_s7, ey_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// azimuth rotation about z
			cax_s1 <= coefs.ca * point_x;
			say_s1 <= coefs.sa * point_y;
			cay_s1 <= coefs.ca * point_y;
			sax_s1 <= coefs.sa * point_x;
			z_s1   <= point_z;

			x1_s2  <= X1_W'(cax_s1) + X1_W'(say_s1);
			y1_s2  <= X1_W'(cay_s1) - X1_W'(sax_s1);
			z_s2   <= z_s1;

			// tilt; cb times z scaled up and back down is exact
			cbz_s3 <= coefs.cb * z_s2;
			sby_s3 <= coefs.sb * y1_s2;
			x1_s3  <= x1_s2;

			z2_s4  <= E_W'(cbz_s3) - E_W'(trunc_q(PROD_W'(sby_s3)));
			x1_s4  <= x1_s3;

			// in-plane rotation
			pcx_s5 <= coefs.cc * x1_s4;
			psz_s5 <= coefs.sc * z2_s4;
			pcz_s5 <= coefs.cc * z2_s4;
			psx_s5 <= coefs.sc * x1_s4;

			tcx_s6 <= E_W'(trunc_q(PROD_W'(pcx_s5)));
			tsz_s6 <= E_W'(trunc_q(PROD_W'(psz_s5)));
			tcz_s6 <= E_W'(trunc_q(PROD_W'(pcz_s5)));
			tsx_s6 <= E_W'(trunc_q(PROD_W'(psx_s5)));

			ex_s7  <= tcx_s6 + tsz_s6;
			ey_s7  <= tcz_s6 - tsx_s6;
		end
	end

	assign ev = v_s7;
	assign ex = ex_s7;
	assign ey = ey_s7;

endmodule

// ===== design/ovp_place.sv =====
// zoom, offset, truncation and clamping stages
`timescale 1ns / 1ps

module ovp_place import ovp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      ev,
	input  logic signed [E_W-1:0]     ex,
	input  logic signed [E_W-1:0]     ey,
	input  logic                      degenerate,
	input  logic [ZOOM_W-1:0]         zoom,
	input  logic signed [CFG_W-1:0]   offset_x,
	input  logic signed [CFG_W-1:0]   offset_y,
	output logic                      out_v,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	output logic                      degenerate_view,
	output logic                      saturated
);

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO =
		{{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

	logic v_s8, v_s9, v_s10;
	logic [E_W-2:0]   mx_s8, my_s8;
	logic             addx_s8, addy_s8, addx_s9, addy_s9, addx_s10, addy_s10;
	logic [PR_W-1:0]  px_s9, py_s9;
	logic signed [SUM_W-1:0] tx_s10, ty_s10;
	logic             frx_s10, fry_s10;

	logic signed [SUM_W-1:0] tx_adj, ty_adj;
	logic             satx, saty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			out_v <= 1'b0;
		end else if (adv) begin
			v_s8  <= ev;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			out_v <= v_s10;
		end
	end

	// truncation toward zero of the sum: pull back toward zero if a fraction was dropped
	always_comb begin
		tx_adj = tx_s10;
		if (addx_s10 && tx_s10 < 0 && frx_s10)
			tx_adj = tx_s10 + SUM_W'(1);
		else if (!addx_s10 && tx_s10 > 0 && frx_s10)
			tx_adj = tx_s10 - SUM_W'(1);
		ty_adj = ty_s10;
		if (addy_s10 && ty_s10 < 0 && fry_s10)
			ty_adj = ty_s10 + SUM_W'(1);
		else if (!addy_s10 && ty_s10 > 0 && fry_s10)
			ty_adj = ty_s10 - SUM_W'(1);
		satx = (tx_adj > SAT_HI) || (tx_adj < SAT_LO);
		saty = (ty_adj > SAT_HI) || (ty_adj < SAT_LO);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s8   <= ex[E_W-1] ? (E_W-1)'(-ex) : (E_W-1)'(ex);
			my_s8   <= ey[E_W-1] ? (E_W-1)'(-ey) : (E_W-1)'(ey);
			addx_s8 <= !ex[E_W-1];
			// screen y grows downward
			addy_s8 <= ey[E_W-1];

			px_s9   <= mx_s8 * zoom;
			py_s9   <= my_s8 * zoom;
			addx_s9 <= addx_s8;
			addy_s9 <= addy_s8;

			tx_s10  <= addx_s9 ? SUM_W'(offset_x) + SUM_W'(px_s9[PR_W-1:PLACE_SH])
			                   : SUM_W'(offset_x) - SUM_W'(px_s9[PR_W-1:PLACE_SH]);
			ty_s10  <= addy_s9 ? SUM_W'(offset_y) + SUM_W'(py_s9[PR_W-1:PLACE_SH])
			                   : SUM_W'(offset_y) - SUM_W'(py_s9[PR_W-1:PLACE_SH]);
			frx_s10 <= |px_s9[PLACE_SH-1:0];
			fry_s10 <= |py_s9[PLACE_SH-1:0];
			addx_s10 <= addx_s9;
			addy_s10 <= addy_s9;

			if (degenerate) begin
				screen_x  <= offset_x;
				screen_y  <= offset_y;
				saturated <= 1'b0;
			end else begin
				screen_x  <= tx_adj > SAT_HI ? COORD_W'(SAT_HI) :
				             tx_adj < SAT_LO ? COORD_W'(SAT_LO) : COORD_W'(tx_adj);
				screen_y  <= ty_adj > SAT_HI ? COORD_W'(SAT_HI) :
				             ty_adj < SAT_LO ? COORD_W'(SAT_LO) : COORD_W'(ty_adj);
				saturated <= satx || saty;
			end
			degenerate_view <= degenerate;
		end
	end

endmodule

// ===== design/orthographic_view_projection_core.sv =====
// an accepted point passes stages s1 to s10 to its screen position at the output register
// throughput: one point per cycle; the whole pipeline holds while the output request waits
// after reset and after every write to a defined register the coefficient sequencer runs
// again, bound by its bit-serial divider and square root, which it skips when the view has
// zero x/y length; in_ready stays low until it finishes
// arst_n clears all control state and loads the register reset values
`timescale 1ns / 1ps
`include "orthographic_view_projection_core_assert.svh"

module orthographic_view_projection_core import ovp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	output logic                      degenerate_view,
	output logic                      saturated
);

	logic signed [CFG_W-1:0] view_x_q, view_y_q, view_z_q, offset_x_q, offset_y_q;
	logic [ZOOM_W-1:0]       zoom_q;
	logic [ANG_W-1:0]        angle_q;
	logic                    cfg_hit;
	logic                    restart;
	logic                    adv;
	coef_t                   coefs;
	logic                    ev;
	logic signed [E_W-1:0]   ex, ey;
	logic                    at_limit;

	always_comb begin
		unique case (cfg_index)
			REG_VIEW_X, REG_VIEW_Y, REG_VIEW_Z, REG_ZOOM,
			REG_ANGLE, REG_OFFSET_X, REG_OFFSET_Y: cfg_hit = 1'b1;
			default:                              cfg_hit = 1'b0;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && cfg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q   <= RST_VIEW_X;
			view_y_q   <= RST_VIEW_Y;
			view_z_q   <= RST_VIEW_Z;
			zoom_q     <= RST_ZOOM;
			angle_q    <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VIEW_X:   view_x_q   <= cfg_data;
				REG_VIEW_Y:   view_y_q   <= cfg_data;
				REG_VIEW_Z:   view_z_q   <= cfg_data;
				REG_ZOOM:     zoom_q     <= cfg_data;
				REG_ANGLE:    angle_q    <= cfg_data;
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// every stage moves when the output register is empty or being drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv && coefs.ready;

	ovp_coef u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.view_x     (view_x_q),
		.view_y     (view_y_q),
		.view_z     (view_z_q),
		.view_angle (angle_q),
		.coefs      (coefs)
	);

	ovp_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (in_valid && coefs.ready),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.coefs   (coefs),
		.ev      (ev),
		.ex      (ex),
		.ey      (ey)
	);

	ovp_place u_place (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.ev              (ev),
		.ex              (ex),
		.ey              (ey),
		.degenerate      (coefs.degenerate),
		.zoom            (zoom_q),
		.offset_x        (offset_x_q),
		.offset_y        (offset_y_q),
		.out_v           (out_valid),
		.screen_x        (screen_x),
		.screen_y        (screen_y),
		.degenerate_view (degenerate_view),
		.saturated       (saturated)
	);

	assign at_limit = screen_x == 16'sh7fff || screen_x == -16'sh8000 ||
	                  screen_y == 16'sh7fff || screen_y == -16'sh8000;

	`OVP_ASSERT_IMPL(a_degen_no_sat, out_valid && degenerate_view, !saturated)
	`OVP_ASSERT_IMPL(a_sat_at_limit, out_valid && saturated, at_limit)

endmodule

// ===== bench/orthographic_view_projection_core_tb.sv =====
// testbench of the orthographic view projection core with its own bit-true projection predictor
`timescale 1ns / 1ps

module orthographic_view_projection_core_tb;
	import ovp_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 30;
	localparam longint unsigned Q28_UNIT = 64'd1 << 28;

	typedef struct {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic               degen;
		logic               sat;
	} screen_pos_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic signed [COORD_W-1:0] point_z = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] screen_x;
	logic signed [COORD_W-1:0] screen_y;
	logic                      degenerate_view;
	logic                      saturated;

	orthographic_view_projection_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow registers and derived coefficients
	logic signed [15:0] view_x, view_y, view_z, off_x, off_y;
	logic [15:0]        zoom_q88, angle;
	longint             coef [6];
	bit                 degen_view;

	screen_pos_t pending_pos [$];
	int  fail_count = 0;
	int  points_sent = 0;
	int  points_checked = 0;
	int  regs_written = 0;
	int  saturated_seen = 0;
	int  degenerate_seen = 0;
	bit  src_gaps = 1'b0;
	bit  snk_stalls = 1'b0;
	bit  hold_req = 1'b0;
	int  idle_cycles = 0;

	function automatic longint unsigned mag64(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint unsigned isqrt_u64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// floor(sqrt(num * 2^32 / den))
	function automatic longint root_of_ratio(longint unsigned num, longint unsigned den);
		longint unsigned q, rem;
		q = num / den;
		rem = num % den;
		for (int i = 0; i < 2 * COEF_F; i++) begin
			rem <<= 1;
			q <<= 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		return longint'(isqrt_u64(q));
	endfunction

	function automatic longint q28_round(longint unsigned v);
		return longint'((v + (64'd1 << (Q_SH - 1))) >> Q_SH);
	endfunction

	function automatic void derive_coefs();
		longint vx, vy, vz, r, sn, cs, ca, sa, sb;
		longint unsigned s2, t2sum, a, t, t2, s, c;
		int unsigned quad;
		vx = view_x;
		vy = view_y;
		vz = view_z;
		s2 = vx * vx + vy * vy;
		t2sum = s2 + vz * vz;
		degen_view = (s2 == 0);
		if (s2 != 0) begin
			ca = root_of_ratio(vy * vy, s2);
			sa = root_of_ratio(vx * vx, s2);
			sb = root_of_ratio(vz * vz, t2sum);
			coef[0] = vy < 0 ? -ca : ca;
			coef[1] = vx > 0 ? -sa : sa;
			coef[2] = root_of_ratio(s2, t2sum);
			coef[3] = vz < 0 ? -sb : sb;
		end else begin
			for (int i = 0; i < 4; i++)
				coef[i] = 0;
		end
		a = angle;
		quad = ((a + 64'h2000) >> 14) & 3;
		r = longint'((a + 64'h2000) & 64'h3FFF) - 64'sh2000;
		t = (mag64(r) * longint'(TWO_PI_Q28)) >> 16;
		t2 = (t * t) >> 28;
		s = Q28_UNIT - t2 / 42;
		s = Q28_UNIT - ((t2 * s) >> 28) / 20;
		s = Q28_UNIT - ((t2 * s) >> 28) / 6;
		s = (t * s) >> 28;
		c = Q28_UNIT - t2 / 56;
		c = Q28_UNIT - ((t2 * c) >> 28) / 30;
		c = Q28_UNIT - ((t2 * c) >> 28) / 12;
		c = Q28_UNIT - ((t2 * c) >> 28) / 2;
		sn = q28_round(s);
		if (r < 0)
			sn = -sn;
		cs = q28_round(c);
		case (quad)
			0: begin coef[4] = cs;  coef[5] = sn;  end
			1: begin coef[4] = -sn; coef[5] = cs;  end
			2: begin coef[4] = -cs; coef[5] = -sn; end
			default: begin coef[4] = sn; coef[5] = -cs; end
		endcase
	endfunction

	// c * v / 2^16 truncated toward zero
	function automatic longint coef_mul(longint c, longint v);
		longint unsigned m, cm, fm, r;
		m = mag64(v);
		cm = mag64(c);
		fm = (64'd1 << COEF_F) - 1;
		r = cm * (m >> COEF_F) + ((cm * (m & fm)) >> COEF_F);
		return ((c < 0) != (v < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint place_coord(longint o, longint e, bit neg);
		longint unsigned m, fm, p, a;
		longint ip, t;
		bit fr;
		m = mag64(e);
		fm = (64'd1 << COEF_F) - 1;
		p = (m & fm) * zoom_q88;
		a = (m >> COEF_F) * zoom_q88 + (p >> COEF_F);
		ip = longint'(a >> 8);
		fr = ((p & fm) != 0) || ((a & 255) != 0);
		if ((e < 0) == neg) begin
			t = o + ip;
			if (t < 0 && fr)
				t += 1;
		end else begin
			t = o - ip;
			if (t > 0 && fr)
				t -= 1;
		end
		return t;
	endfunction

	function automatic longint clamp_coord(longint v, inout bit sat);
		longint hi, lo;
		hi = (longint'(1) << (COORD_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat = 1'b1;
			return hi;
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic screen_pos_t project_point(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz);
		screen_pos_t res;
		longint x, y, z, x1, y1, z2, ex, ey, sx, sy;
		bit sat;
		sat = 1'b0;
		if (degen_view) begin
			sx = off_x;
			sy = off_y;
		end else begin
			x = px;
			y = py;
			z = pz;
			x1 = coef[0] * x + coef[1] * y;
			y1 = coef[0] * y - coef[1] * x;
			z2 = coef_mul(coef[2], z * 65536) - coef_mul(coef[3], y1);
			ex = coef_mul(coef[4], x1) + coef_mul(coef[5], z2);
			ey = coef_mul(coef[4], z2) - coef_mul(coef[5], x1);
			sx = place_coord(off_x, ex, 1'b0);
			sy = place_coord(off_y, ey, 1'b1);
		end
		sx = clamp_coord(sx, sat);
		sy = clamp_coord(sy, sat);
		res.sx = sx[COORD_W-1:0];
		res.sy = sy[COORD_W-1:0];
		res.degen = degen_view;
		res.sat = sat;
		return res;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 200)) - 16'd100;
			3: return 16'($urandom_range(0, 4000)) - 16'd2000;
			default: return 16'($urandom);
		endcase
	endfunction

	// tasks start and end at a falling edge
	task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
		int gap;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		point_x = px;
		point_y = py;
		point_z = pz;
		do @(posedge clk); while (!in_ready);
		pending_pos.push_back(project_point(px, py, pz));
		points_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_random_points(int n);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic wait_idle();
		while (pending_pos.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		regs_written++;
		case (idx)
			REG_VIEW_X:   view_x = val;
			REG_VIEW_Y:   view_y = val;
			REG_VIEW_Z:   view_z = val;
			REG_ZOOM:     zoom_q88 = val;
			REG_ANGLE:    angle = val;
			REG_OFFSET_X: off_x = val;
			REG_OFFSET_Y: off_y = val;
			default: ;
		endcase
		if (idx != REG_UNUSED)
			derive_coefs();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_view(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
		wait_idle();
		write_reg(REG_VIEW_X, vx);
		write_reg(REG_VIEW_Y, vy);
		write_reg(REG_VIEW_Z, vz);
	endtask

	task automatic test_reset_config();
		send_point(16'h0000, 16'h0000, 16'h0000);
		send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(16'h8000, 16'h8000, 16'h8000);
		send_point(16'h7FFF, 16'h8000, 16'h0000);
		send_point(16'h0001, 16'hFFFF, 16'h0001);
	endtask

	task automatic test_directed();
		// zero x/y view length gives the offset
		set_view(16'h0000, 16'h0000, 16'h1234);
		write_reg(REG_OFFSET_X, 16'h7FFF);
		write_reg(REG_OFFSET_Y, 16'h8000);
		send_point(16'h7FFF, 16'h8000, 16'h7FFF);
		send_point(16'h0000, 16'h0000, 16'h0000);
		// full-scale view and zoom to force clamping
		set_view(16'h7FFF, 16'h8000, 16'h7FFF);
		write_reg(REG_ZOOM, 16'hFFFF);
		send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(16'h8000, 16'h7FFF, 16'h8000);
		wait_idle();
		write_reg(REG_ZOOM, 16'h0000);
		write_reg(REG_OFFSET_X, 16'h0000);
		write_reg(REG_OFFSET_Y, 16'h0000);
		send_point(16'h7FFF, 16'h8000, 16'h7FFF);
		wait_idle();
		write_reg(REG_ZOOM, 16'h0100);
		// angles on quadrant and octant boundaries
		for (int q = 0; q < 6; q++) begin
			wait_idle();
			case (q)
				0: write_reg(REG_ANGLE, 16'h2000);
				1: write_reg(REG_ANGLE, 16'h4000);
				2: write_reg(REG_ANGLE, 16'h8000);
				3: write_reg(REG_ANGLE, 16'hBFFF);
				4: write_reg(REG_ANGLE, 16'hE000);
				default: write_reg(REG_ANGLE, 16'hFFFF);
			endcase
			send_point(16'h1000, 16'hF000, 16'h0800);
			send_point(16'h8000, 16'h7FFF, 16'h0001);
		end
		// a write past the register list changes nothing
		wait_idle();
		write_reg(REG_UNUSED, 16'hFFFF);
		send_point(16'h0100, 16'h0200, 16'h0300);
		send_point(16'hFF00, 16'hFE00, 16'hFD00);
	endtask

	task automatic test_random_configs(int phases, int per_phase);
		logic [15:0] v [7];
		for (int p = 0; p < phases; p++) begin
			for (int i = 0; i < 7; i++)
				v[i] = (i == 3 || i == 4) ? 16'($urandom) : rand_coord();
			if ($urandom_range(0, 7) == 0) begin
				v[0] = 16'h0000;
				v[1] = 16'h0000;
			end
			if ($urandom_range(0, 3) == 0)
				v[3] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			wait_idle();
			write_reg(REG_VIEW_X, v[0]);
			write_reg(REG_VIEW_Y, v[1]);
			write_reg(REG_VIEW_Z, v[2]);
			write_reg(REG_ZOOM, v[3]);
			write_reg(REG_ANGLE, v[4]);
			write_reg(REG_OFFSET_X, v[5]);
			write_reg(REG_OFFSET_Y, v[6]);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, 16'($urandom));
			send_random_points(per_phase);
		end
	endtask

	task automatic test_output_holdoff();
		wait_idle();
		hold_req = 1'b1;
		src_gaps = 1'b0;
		send_random_points(50);
		src_gaps = 1'b1;
	endtask

	task automatic test_sender_pause();
		send_random_points(20);
		while (pending_pos.size() != 0)
			@(negedge clk);
		send_random_points(20);
	endtask

	task automatic test_streaming();
		wait_idle();
		src_gaps = 1'b0;
		snk_stalls = 1'b0;
		write_reg(REG_VIEW_X, 16'($urandom));
		write_reg(REG_VIEW_Y, 16'($urandom));
		write_reg(REG_ANGLE, 16'($urandom));
		send_random_points(80);
	endtask

	// output side: random stall bursts and one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_ready = 1'b1;
			end else if (snk_stalls && $urandom_range(0, 6) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		screen_pos_t exp_pos;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pos.size() == 0) begin
				$error("result with no point outstanding: x=%0d y=%0d", screen_x, screen_y);
				fail_count++;
			end else begin
				exp_pos = pending_pos.pop_front();
				points_checked++;
				if (exp_pos.sat)
					saturated_seen++;
				if (exp_pos.degen)
					degenerate_seen++;
				if (screen_x !== exp_pos.sx) begin
					$error("screen_x expected %0d actual %0d", $signed(exp_pos.sx), screen_x);
					fail_count++;
				end
				if (screen_y !== exp_pos.sy) begin
					$error("screen_y expected %0d actual %0d", $signed(exp_pos.sy), screen_y);
					fail_count++;
				end
				if (degenerate_view !== exp_pos.degen) begin
					$error("degenerate_view expected %0b actual %0b", exp_pos.degen,
						degenerate_view);
					fail_count++;
				end
				if (saturated !== exp_pos.sat) begin
					$error("saturated expected %0b actual %0b", exp_pos.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	// no request moving on any channel for too long ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_pos.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		view_x = RST_VIEW_X;
		view_y = RST_VIEW_Y;
		view_z = RST_VIEW_Z;
		zoom_q88 = RST_ZOOM;
		angle = '0;
		off_x = '0;
		off_y = '0;
		derive_coefs();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_config();
		test_directed();
		src_gaps = 1'b1;
		snk_stalls = 1'b1;
		test_random_configs(9, 60);
		test_output_holdoff();
		test_sender_pause();
		test_streaming();
		wait_idle();
		$display("covered %0d points and %0d register writes, %0d results checked",
			points_sent, regs_written, points_checked);
		$display("results with clamping: %0d, with zero x/y view: %0d",
			saturated_seen, degenerate_seen);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/ovp_pkg.sv
design/ovp_coef.sv
design/ovp_xform.sv
design/ovp_place.sv
design/orthographic_view_projection_core.sv
bench/orthographic_view_projection_core_tb.sv
